### rtl/epoch_time_to_decimal_year_assert.svh
// Assertion macros shared by the conversion pipeline.
`ifndef EPOCH_TIME_TO_DECIMAL_YEAR_ASSERT_SVH
`define EPOCH_TIME_TO_DECIMAL_YEAR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ETDY_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etdy assertion failed");

// Next-cycle implication, disabled during reset.
`define ETDY_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etdy assertion failed");

`endif

### rtl/etdy_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etdy_pkg
// Constants, reciprocals and transaction types for the epoch-to-year pipeline.
// ----------------------------------------------------------------------------
package etdy_pkg;

  localparam int FRAC_BITS_DEF = 40;
  localparam int SECS_W        = 38;
  localparam int USEC_W        = 20;
  localparam int YEAR_W        = 14;
  localparam int FRAC_W        = 40;
  localparam int NUM_W         = 45;
  localparam int REM_W         = NUM_W + 1;

  localparam logic [USEC_W-1:0] USEC_MAX = USEC_W'(999999);

  // Seconds per day is 128 * 675; divide the seconds shifted down by 7 by 675
  localparam logic [31:0] DAY_RECIP  = 32'((64'd1 << 41) / 64'd675);
  localparam logic [22:0] C400_RECIP = 23'((64'd1 << 40) / 64'd146097);
  localparam logic [21:0] C4_RECIP   = 22'((64'd1 << 32) / 64'd1461);

  localparam logic [37:0] SECS_PER_DAY  = 38'd86400;
  localparam logic [21:0] DAYS_TO_EPOCH = 22'd719162;
  localparam logic [21:0] DAYS_400Y     = 22'd146097;
  localparam logic [17:0] DAYS_100Y     = 18'd36524;
  localparam logic [11:0] DAYS_4Y       = 12'd1461;
  localparam logic [10:0] DAYS_1Y       = 11'd365;

  localparam logic [NUM_W-1:0] DEN_COMMON = NUM_W'(64'd31536000000000);
  localparam logic [NUM_W-1:0] DEN_LEAP   = NUM_W'(64'd31622400000000);

  // Calendar split handed to the scaling stages
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic              leap;
    logic [8:0]        day_of_year;
    logic [16:0]       sod;
    logic [USEC_W-1:0] usec;
  } etdy_cal_t;

  // Microseconds into the year handed to the divider
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic              leap;
    logic [NUM_W-1:0]  num;
  } etdy_num_t;

endpackage

### rtl/epoch_time_to_decimal_year.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_time_to_decimal_year
// Converts epoch seconds and microseconds into year and fraction of year.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: epoch_seconds and micro_seconds with item_valid; it
//   is taken on a rising edge with item_valid high and item_stall low.
//   Result transaction: year_number and year_fraction with result_valid; it
//   is taken on a rising edge with result_valid high and result_stall low.
//   The pipeline has eight calendar stages, two scaling stages and a
//   restoring divider that resolves two quotient bits per stage.
//   Throughput is one transaction per cycle while no result is stalled; nothing
//   depends on earlier items. The final divider stage is the output register.
//   A stalled result freezes the whole pipeline, and item_stall is raised
//   in the same cycle, so no transaction is lost or repeated.
//   Synchronous reset clears every valid bit; payload registers keep
//   whatever they held. Microseconds above 999999 are clamped.
// ----------------------------------------------------------------------------
module epoch_time_to_decimal_year #(
  parameter int FRAC_BITS = etdy_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [etdy_pkg::SECS_W-1:0] epoch_seconds,
  input  logic [etdy_pkg::USEC_W-1:0] micro_seconds,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [etdy_pkg::YEAR_W-1:0] year_number,
  output logic [etdy_pkg::FRAC_W-1:0] year_fraction
);
  import etdy_pkg::*;

  `include "epoch_time_to_decimal_year_assert.svh"

  logic      en;
  logic      cal_valid;
  etdy_cal_t cal;
  logic      num_valid;
  etdy_num_t num;

  // Freeze the pipeline while a result is held
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  etdy_calendar u_calendar (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (item_valid),
    .secs_in   (epoch_seconds),
    .usec_in   (micro_seconds),
    .out_valid (cal_valid),
    .cal       (cal)
  );

  etdy_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cal_valid),
    .cal       (cal),
    .out_valid (num_valid),
    .numo      (num)
  );

  etdy_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (num_valid),
    .numi      (num),
    .out_valid (result_valid),
    .year      (year_number),
    .frac      (year_fraction)
  );

  // Day of year stays inside the year length
  `ETDY_ASSERT_IMP(a_doy_range, clk, rst, cal_valid, cal.day_of_year < 9'd366)
  `ETDY_ASSERT_IMP(a_doy_common, clk, rst, cal_valid && !cal.leap, cal.day_of_year < 9'd365)
  // Years start at the epoch year
  `ETDY_ASSERT_IMP(a_year_min, clk, rst, result_valid, year_number >= YEAR_W'(1970))

endmodule

### rtl/etdy_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etdy_calendar
// Eight-stage split of epoch seconds into Gregorian year and day of year.
// ----------------------------------------------------------------------------
module etdy_calendar (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [etdy_pkg::SECS_W-1:0] secs_in,
  input  logic [etdy_pkg::USEC_W-1:0] usec_in,
  output logic                       out_valid,
  output etdy_pkg::etdy_cal_t        cal
);
  import etdy_pkg::*;

  logic [7:0] vld;

  logic [SECS_W-1:0] s1_secs;
  logic [USEC_W-1:0] s1_usec;
  logic [62:0]       s1_prod;
  logic [21:0]       s2_days;
  logic [16:0]       s2_sod;
  logic [USEC_W-1:0] s2_usec;
  logic [21:0]       s3_d;
  logic [44:0]       s3_prod;
  logic [16:0]       s3_sod;
  logic [USEC_W-1:0] s3_usec;
  logic [4:0]        s4_n400;
  logic [17:0]       s4_d400;
  logic [16:0]       s4_sod;
  logic [USEC_W-1:0] s4_usec;
  logic [4:0]        s5_n400;
  logic [1:0]        s5_n100;
  logic [15:0]       s5_d100;
  logic [16:0]       s5_sod;
  logic [USEC_W-1:0] s5_usec;
  logic [4:0]        s6_n400;
  logic [1:0]        s6_n100;
  logic [15:0]       s6_d100;
  logic [37:0]       s6_prod;
  logic [16:0]       s6_sod;
  logic [USEC_W-1:0] s6_usec;
  logic [4:0]        s7_n400;
  logic [1:0]        s7_n100;
  logic [4:0]        s7_n4;
  logic [11:0]       s7_d4;
  logic [16:0]       s7_sod;
  logic [USEC_W-1:0] s7_usec;

  logic [21:0] s2_days_next;
  logic [16:0] s2_sod_next;
  logic [37:0] rem_day;
  logic [4:0]  s4_n400_next;
  logic [17:0] s4_d400_next;
  logic [21:0] rem_400;
  logic [1:0]  s5_n100_next;
  logic [4:0]  s7_n4_next;
  logic [11:0] s7_d4_next;
  logic [15:0] rem_4;
  logic [1:0]  n1;
  logic [YEAR_W-1:0] year_next;

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:0], in_valid};
    end
  end
  assign out_valid = vld[7];

  // Correct the day quotient estimate by one step
  always_comb begin
    rem_day      = s1_secs - 38'(s1_prod[62:41]) * SECS_PER_DAY;
    s2_days_next = s1_prod[62:41];
    s2_sod_next  = rem_day[16:0];
    if (rem_day >= SECS_PER_DAY) begin
      s2_days_next = s1_prod[62:41] + 22'd1;
      s2_sod_next  = 17'(rem_day - SECS_PER_DAY);
    end
  end

  // Correct the 400-year cycle quotient
  always_comb begin
    rem_400      = s3_d - 22'(s3_prod[44:40]) * DAYS_400Y;
    s4_n400_next = s3_prod[44:40];
    s4_d400_next = rem_400[17:0];
    if (rem_400 >= DAYS_400Y) begin
      s4_n400_next = s3_prod[44:40] + 5'd1;
      s4_d400_next = 18'(rem_400 - DAYS_400Y);
    end
  end

  // Count centuries, the last one is open-ended
  always_comb begin
    s5_n100_next = 2'd0;
    if (s4_d400 >= DAYS_100Y) s5_n100_next = 2'd1;
    if (s4_d400 >= 18'(3'd2 * DAYS_100Y)) s5_n100_next = 2'd2;
    if (s4_d400 >= 18'(3'd3 * DAYS_100Y)) s5_n100_next = 2'd3;
  end

  // Correct the 4-year cycle quotient
  always_comb begin
    rem_4      = s6_d100 - 16'(s6_prod[36:32]) * 16'(DAYS_4Y);
    s7_n4_next = s6_prod[36:32];
    s7_d4_next = rem_4[11:0];
    if (rem_4 >= 16'(DAYS_4Y)) begin
      s7_n4_next = s6_prod[36:32] + 5'd1;
      s7_d4_next = 12'(rem_4 - 16'(DAYS_4Y));
    end
  end

  // Count single years, the last one is open-ended
  always_comb begin
    n1 = 2'd0;
    if (s7_d4 >= 12'(DAYS_1Y)) n1 = 2'd1;
    if (s7_d4 >= 12'(3'd2 * DAYS_1Y)) n1 = 2'd2;
    if (s7_d4 >= 12'(3'd3 * DAYS_1Y)) n1 = 2'd3;
    year_next = YEAR_W'(s7_n400) * YEAR_W'(400) + YEAR_W'(s7_n100) * YEAR_W'(100)
              + YEAR_W'(s7_n4) * YEAR_W'(4) + YEAR_W'(n1) + YEAR_W'(1);
  end

  // Hold the payload registers while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      s1_secs <= secs_in;
      s1_usec <= (usec_in > USEC_MAX) ? USEC_MAX : usec_in;
      s1_prod <= 63'(secs_in[37:7]) * 63'(DAY_RECIP);

      s2_days <= s2_days_next;
      s2_sod  <= s2_sod_next;
      s2_usec <= s1_usec;

      s3_d    <= s2_days + DAYS_TO_EPOCH;
      s3_prod <= 45'(s2_days + DAYS_TO_EPOCH) * 45'(C400_RECIP);
      s3_sod  <= s2_sod;
      s3_usec <= s2_usec;

      s4_n400 <= s4_n400_next;
      s4_d400 <= s4_d400_next;
      s4_sod  <= s3_sod;
      s4_usec <= s3_usec;

      s5_n400 <= s4_n400;
      s5_n100 <= s5_n100_next;
      s5_d100 <= 16'(s4_d400 - 18'(s5_n100_next) * DAYS_100Y);
      s5_sod  <= s4_sod;
      s5_usec <= s4_usec;

      s6_n400 <= s5_n400;
      s6_n100 <= s5_n100;
      s6_d100 <= s5_d100;
      s6_prod <= 38'(s5_d100) * 38'(C4_RECIP);
      s6_sod  <= s5_sod;
      s6_usec <= s5_usec;

      s7_n400 <= s6_n400;
      s7_n100 <= s6_n100;
      s7_n4   <= s7_n4_next;
      s7_d4   <= s7_d4_next;
      s7_sod  <= s6_sod;
      s7_usec <= s6_usec;

      cal.year        <= year_next;
      cal.leap        <= (n1 == 2'd3) && ((s7_n4 != 5'd24) || (s7_n100 == 2'd3));
      cal.day_of_year <= 9'(s7_d4 - 12'(n1) * 12'(DAYS_1Y));
      cal.sod         <= s7_sod;
      cal.usec        <= s7_usec;
    end
  end

endmodule

### rtl/etdy_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etdy_scale
// Two-stage conversion of day, second and microsecond into microseconds.
// ----------------------------------------------------------------------------
module etdy_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  etdy_pkg::etdy_cal_t cal,
  output logic                out_valid,
  output etdy_pkg::etdy_num_t numo
);
  import etdy_pkg::*;

  logic [1:0]        vld;
  logic [24:0]       siy;
  logic [USEC_W-1:0] usec;
  logic [YEAR_W-1:0] year;
  logic              leap;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_valid};
    end
  end
  assign out_valid = vld[1];

  // Seconds into the year, then microseconds into the year
  always_ff @(posedge clk) begin
    if (en) begin
      siy       <= 25'(cal.day_of_year) * 25'(86400) + 25'(cal.sod);
      usec      <= cal.usec;
      year      <= cal.year;
      leap      <= cal.leap;
      numo.num  <= NUM_W'(siy) * NUM_W'(1000000) + NUM_W'(usec);
      numo.year <= year;
      numo.leap <= leap;
    end
  end

endmodule

### rtl/etdy_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etdy_divider
// Pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module etdy_divider #(
  parameter int FRAC_BITS = etdy_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  etdy_pkg::etdy_num_t         numi,
  output logic                        out_valid,
  output logic [etdy_pkg::YEAR_W-1:0] year,
  output logic [etdy_pkg::FRAC_W-1:0] frac
);
  import etdy_pkg::*;

  localparam int NSTG = (FRAC_BITS + 1) / 2;

  logic [REM_W-1:0]  rem_a  [NSTG+1];
  logic [FRAC_W-1:0] quo_a  [NSTG+1];
  logic [YEAR_W-1:0] year_a [NSTG+1];
  logic              leap_a [NSTG+1];
  logic [NSTG:0]     vld_a;

  assign rem_a[0]  = REM_W'(numi.num);
  assign quo_a[0]  = '0;
  assign year_a[0] = numi.year;
  assign leap_a[0] = numi.leap;
  assign vld_a[0]  = in_valid;

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    logic [REM_W-1:0]  r;
    logic [FRAC_W-1:0] q;
    logic [REM_W-1:0]  den;

    // Shift, compare and subtract for each quotient bit of this stage
    always_comb begin
      den = REM_W'(leap_a[g] ? DEN_LEAP : DEN_COMMON);
      r   = rem_a[g];
      q   = quo_a[g];
      for (int k = 0; k < 2; k++) begin
        if (g * 2 + k < FRAC_BITS) begin
          r = {r[REM_W-2:0], 1'b0};
          q = {q[FRAC_W-2:0], 1'b0};
          if (r >= den) begin
            r    = r - den;
            q[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_a[g+1] <= 1'b0;
      end else if (en) begin
        vld_a[g+1] <= vld_a[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[g+1]  <= r;
        quo_a[g+1]  <= q;
        year_a[g+1] <= year_a[g];
        leap_a[g+1] <= leap_a[g];
      end
    end
  end

  assign out_valid = vld_a[NSTG];
  assign year      = year_a[NSTG];
  assign frac      = quo_a[NSTG];

endmodule
